[hdl/sst_scan_pkg.sv]
package sst_scan_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned RES_W    = 12;
    localparam int unsigned ALPHA_W  = 8;
    localparam int unsigned BGR_W    = 24;
    localparam int unsigned ACCUM_W  = 32;
    localparam int unsigned COUNT_W  = 4;
    localparam int unsigned KW_W     = 3;
    localparam int unsigned REASON_W = 2;
    localparam int unsigned CFG_IDX_W = 1;

    localparam logic [RES_W-1:0] FALLBACK_W_RST = 12'd384;
    localparam logic [RES_W-1:0] FALLBACK_H_RST = 12'd288;

    localparam logic [COUNT_W-1:0] COUNT_SAT  = 4'd9;
    localparam logic [COUNT_W-1:0] COUNT_RGB  = 4'd6;
    localparam logic [COUNT_W-1:0] COUNT_ARGB = 4'd8;
    localparam logic [KW_W-1:0]    KW_LEN     = 3'd7;
    localparam logic [ALPHA_W-1:0] ALPHA_OPAQUE = 8'hff;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FALLBACK_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FALLBACK_HEIGHT = 1'd1;

    // report reason codes
    localparam logic [REASON_W-1:0] RSN_NONE    = 2'd0;
    localparam logic [REASON_W-1:0] RSN_COLOR   = 2'd1;
    localparam logic [REASON_W-1:0] RSN_RES     = 2'd2;

    localparam logic [BYTE_W-1:0] CH_BACKSLASH = 8'h5c;
    localparam logic [BYTE_W-1:0] CH_AMP       = 8'h26;
    localparam logic [BYTE_W-1:0] CH_N         = 8'h4e;
    localparam logic [BYTE_W-1:0] CH_H         = 8'h48;
    localparam logic [BYTE_W-1:0] CH_P         = 8'h50;
    localparam logic [BYTE_W-1:0] CH_X         = 8'h58;
    localparam logic [BYTE_W-1:0] CH_Y         = 8'h59;

    typedef struct packed {
        logic                status;
        logic [REASON_W-1:0] reason;
        logic                line_break_flag;
        logic                fallback_flag;
        logic                color_found;
        logic [ALPHA_W-1:0]  color_alpha;
        logic [BGR_W-1:0]    color_bgr;
        logic [RES_W-1:0]    normalized_width;
        logic [RES_W-1:0]    normalized_height;
    } t_report;

endpackage

[hdl/sst_scan_in_if.sv]
interface sst_scan_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       byte_present;
    logic       end_of_text;

    modport source (output valid, output text_byte, output byte_present,
                    output end_of_text, input ready);
    modport sink (input valid, input text_byte, input byte_present,
                  input end_of_text, output ready);
endinterface

[hdl/sst_scan_out_if.sv]
interface sst_scan_out_if;
    logic        valid;
    logic        ready;
    logic        status;
    logic [1:0]  reason;
    logic        line_break_flag;
    logic        fallback_flag;
    logic        color_found;
    logic [7:0]  color_alpha;
    logic [23:0] color_bgr;
    logic [11:0] normalized_width;
    logic [11:0] normalized_height;

    modport source (output valid, output status, output reason, output line_break_flag,
                    output fallback_flag, output color_found, output color_alpha,
                    output color_bgr, output normalized_width,
                    output normalized_height, input ready);
    modport sink (input valid, input status, input reason, input line_break_flag,
                  input fallback_flag, input color_found, input color_alpha,
                  input color_bgr, input normalized_width, input normalized_height,
                  output ready);
endinterface

[hdl/subtitle_style_text_scanner_top.sv]
// channel   | dir | handshake     | payload
// i_in      | in  | valid / ready | text_byte, byte_present, end_of_text
// o_out     | out | valid / ready | one report per text, on its end_of_text item
// i_cfg_*   | in  | write enable  | fallback width / height, 12 bits
//
// one byte per cycle unless a stalled report holds an end-of-text item; a transaction passes
// through the input register and its report is registered in the output register
// synchronous active-low reset clears the text state, both valid bits and
// restores the fallback registers to 384 x 288
// a stalled report holds only end-of-text transactions; other bytes keep flowing
module subtitle_style_text_scanner_top (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [sst_scan_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [sst_scan_pkg::RES_W-1:0]         i_cfg_data,
    sst_scan_in_if.sink                            i_in,
    sst_scan_out_if.source                         o_out
);
    import sst_scan_pkg::*;

    typedef enum logic [1:0] {
        PH_SEARCH,
        PH_COLLECT,
        PH_DONE
    } t_phase;

    // input register
    logic              r_s1_valid;
    logic [BYTE_W-1:0] r_s1_byte;
    logic              r_s1_present;
    logic              r_s1_last;

    // text state
    logic               r_prev_bs, n_prev_bs;
    logic               r_lb_seen, n_lb_seen;
    logic               r_prev_amp, n_prev_amp;
    t_phase             r_phase, n_phase;
    logic [COUNT_W-1:0] r_count, n_count;
    logic [ACCUM_W-1:0] r_accum, n_accum;
    logic [KW_W-1:0]    r_kw, n_kw;
    logic               r_res_x, n_res_x;
    logic               r_res_y, n_res_y;

    logic [RES_W-1:0] r_fb_width;
    logic [RES_W-1:0] r_fb_height;

    logic    r_out_valid;
    t_report r_report, n_report;

    logic s1_advance;
    logic [4:0] nib;

    function automatic logic [4:0] nibble_of(input logic [BYTE_W-1:0] b);
        if (b >= 8'h30 && b <= 8'h39) return {1'b0, 4'(b - 8'h30)};
        if (b >= 8'h41 && b <= 8'h46) return {1'b0, 4'(b - 8'h37)};
        if (b >= 8'h61 && b <= 8'h66) return {1'b0, 4'(b - 8'h57)};
        return 5'h10;
    endfunction

    function automatic logic [BYTE_W-1:0] kw_char(input logic [KW_W-1:0] k);
        logic [BYTE_W-1:0] c;
        case (k)
            3'd0: c = 8'h50;  // P
            3'd1: c = 8'h6c;  // l
            3'd2: c = 8'h61;  // a
            3'd3: c = 8'h79;  // y
            3'd4: c = 8'h52;  // R
            3'd5: c = 8'h65;  // e
            3'd6: c = 8'h73;  // s
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    assign s1_advance = r_s1_valid && (!r_s1_last || !r_out_valid || o_out.ready);
    assign i_in.ready = !r_s1_valid || s1_advance;
    assign nib = nibble_of(r_s1_byte);

    always_comb begin
        n_prev_bs  = r_prev_bs;
        n_lb_seen  = r_lb_seen;
        n_prev_amp = r_prev_amp;
        n_phase    = r_phase;
        n_count    = r_count;
        n_accum    = r_accum;
        n_kw       = r_kw;
        n_res_x    = r_res_x;
        n_res_y    = r_res_y;

        if (r_s1_present) begin
            if (r_prev_bs && r_s1_byte == CH_N) begin
                n_lb_seen = 1'b1;
            end
            n_prev_bs = (r_s1_byte == CH_BACKSLASH);

            case (r_phase)
                PH_SEARCH: begin
                    if (r_prev_amp && r_s1_byte == CH_H) begin
                        n_phase = PH_COLLECT;
                    end
                end
                PH_COLLECT: begin
                    if (!nib[4]) begin
                        if (r_count < COUNT_SAT) begin
                            n_count = r_count + 1'b1;
                        end
                        n_accum = {r_accum[ACCUM_W-5:0], nib[3:0]};
                    end else begin
                        n_phase = PH_DONE;
                    end
                end
                default: ;
            endcase
            n_prev_amp = (r_s1_byte == CH_AMP);

            if (r_kw >= KW_LEN) begin
                if (r_s1_byte == CH_X) n_res_x = 1'b1;
                if (r_s1_byte == CH_Y) n_res_y = 1'b1;
                n_kw = (r_s1_byte == CH_P) ? 3'd1 : 3'd0;
            end else if (r_s1_byte == kw_char(r_kw)) begin
                n_kw = r_kw + 1'b1;
            end else begin
                n_kw = (r_s1_byte == CH_P) ? 3'd1 : 3'd0;
            end
        end

        n_report = '0;
        n_report.line_break_flag = n_lb_seen;
        if (n_phase != PH_SEARCH) begin
            if (n_count == COUNT_ARGB) begin
                n_report.color_found = 1'b1;
                n_report.color_alpha = ALPHA_OPAQUE - n_accum[ACCUM_W-1 -: ALPHA_W];
                n_report.color_bgr   = n_accum[BGR_W-1:0];
            end else if (n_count == COUNT_RGB) begin
                n_report.color_found = 1'b1;
                n_report.color_alpha = ALPHA_OPAQUE;
                n_report.color_bgr   = n_accum[BGR_W-1:0];
            end else begin
                n_report.status = 1'b1;
                n_report.reason = RSN_COLOR;
            end
        end
        if (!n_report.status && !(n_res_x && n_res_y)) begin
            n_report.reason            = RSN_RES;
            n_report.fallback_flag     = 1'b1;
            n_report.normalized_width  = r_fb_width;
            n_report.normalized_height = r_fb_height;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid   <= 1'b0;
            r_s1_present <= 1'b0;
            r_s1_last    <= 1'b0;
            r_out_valid  <= 1'b0;
            r_prev_bs    <= 1'b0;
            r_lb_seen    <= 1'b0;
            r_prev_amp   <= 1'b0;
            r_phase      <= PH_SEARCH;
            r_count      <= '0;
            r_accum      <= '0;
            r_kw         <= '0;
            r_res_x      <= 1'b0;
            r_res_y      <= 1'b0;
            r_fb_width   <= FALLBACK_W_RST;
            r_fb_height  <= FALLBACK_H_RST;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_FALLBACK_WIDTH:  r_fb_width  <= i_cfg_data;
                    CFG_FALLBACK_HEIGHT: r_fb_height <= i_cfg_data;
                    default: ;
                endcase
            end

            if (i_in.ready) begin
                r_s1_valid <= i_in.valid;
                if (i_in.valid) begin
                    r_s1_present <= i_in.byte_present;
                    r_s1_last    <= i_in.end_of_text;
                end
            end

            // a new report or a held one that is not taken yet
            r_out_valid <= (s1_advance && r_s1_last) || (r_out_valid && !o_out.ready);

            if (s1_advance) begin
                if (r_s1_last) begin
                    // report and start a fresh text
                    r_prev_bs   <= 1'b0;
                    r_lb_seen   <= 1'b0;
                    r_prev_amp  <= 1'b0;
                    r_phase     <= PH_SEARCH;
                    r_count     <= '0;
                    r_accum     <= '0;
                    r_kw        <= '0;
                    r_res_x     <= 1'b0;
                    r_res_y     <= 1'b0;
                end else begin
                    r_prev_bs   <= n_prev_bs;
                    r_lb_seen   <= n_lb_seen;
                    r_prev_amp  <= n_prev_amp;
                    r_phase     <= n_phase;
                    r_count     <= n_count;
                    r_accum     <= n_accum;
                    r_kw        <= n_kw;
                    r_res_x     <= n_res_x;
                    r_res_y     <= n_res_y;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_s1_byte <= i_in.text_byte;
        end
        if (s1_advance && r_s1_last) begin
            r_report <= n_report;
        end
    end

    assign o_out.valid             = r_out_valid;
    assign o_out.status            = r_report.status;
    assign o_out.reason            = r_report.reason;
    assign o_out.line_break_flag   = r_report.line_break_flag;
    assign o_out.fallback_flag     = r_report.fallback_flag;
    assign o_out.color_found       = r_report.color_found;
    assign o_out.color_alpha       = r_report.color_alpha;
    assign o_out.color_bgr         = r_report.color_bgr;
    assign o_out.normalized_width  = r_report.normalized_width;
    assign o_out.normalized_height = r_report.normalized_height;

endmodule

[tb/subtitle_style_text_scanner_top_tb.sv]
`timescale 1ns / 100ps

module subtitle_style_text_scanner_top_tb;
    import sst_scan_pkg::*;

    typedef enum logic [1:0] {HEX_SEEK, HEX_TAKE, HEX_DONE} t_hex_phase;

    typedef struct {
        logic [7:0] b;
        logic       present;
        logic       eot;
        logic       typed;
        t_report    want;
    } t_dir_step;

    localparam logic [55:0] PLAYRES = "PlayRes";

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [RES_W-1:0]     i_cfg_data;

    sst_scan_in_if  in_ch ();
    sst_scan_out_if out_ch ();

    subtitle_style_text_scanner_top u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    // scanner state mirrored by the testbench
    logic             after_backslash;
    logic             break_seen;
    logic             after_amp;
    t_hex_phase       hex_phase;
    logic [COUNT_W-1:0] digit_cnt;
    logic [ACCUM_W-1:0] digit_acc;
    logic [KW_W-1:0]  key_len;
    logic             saw_res_x;
    logic             saw_res_y;
    logic [RES_W-1:0] fb_width;
    logic [RES_W-1:0] fb_height;

    t_report    reports_due[$];
    logic [7:0] text_buf[$];
    t_dir_step  dir_steps[$];

    logic idle_en;
    int   items_sent;
    int   texts_sent;
    int   reports_seen;
    int   fail_cnt;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("timeout: %0d reports still pending", reports_due.size());
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic logic [4:0] hex_digit_of(input logic [7:0] b);
        if (b >= "0" && b <= "9") return 5'(b - "0");
        if (b >= "A" && b <= "F") return 5'(b - "A" + 8'd10);
        if (b >= "a" && b <= "f") return 5'(b - "a" + 8'd10);
        return 5'd16;
    endfunction

    function automatic t_report report_of(input logic st, input logic [1:0] rsn,
                                          input logic lb, input logic fb,
                                          input logic found, input logic [7:0] alpha,
                                          input logic [23:0] bgr,
                                          input logic [11:0] w, input logic [11:0] h);
        t_report r;
        r.status            = st;
        r.reason            = rsn;
        r.line_break_flag   = lb;
        r.fallback_flag     = fb;
        r.color_found       = found;
        r.color_alpha       = alpha;
        r.color_bgr         = bgr;
        r.normalized_width  = w;
        r.normalized_height = h;
        return r;
    endfunction

    task automatic clear_text_state();
        after_backslash = 1'b0;
        break_seen      = 1'b0;
        after_amp       = 1'b0;
        hex_phase       = HEX_SEEK;
        digit_cnt       = '0;
        digit_acc       = '0;
        key_len         = '0;
        saw_res_x       = 1'b0;
        saw_res_y       = 1'b0;
    endtask

    task automatic scan_text_byte(input logic [7:0] b);
        logic [4:0] nib;
        nib = hex_digit_of(b);
        if (after_backslash && b == CH_N) break_seen = 1'b1;
        after_backslash = (b == CH_BACKSLASH);
        case (hex_phase)
            HEX_SEEK: begin
                if (after_amp && b == CH_H) hex_phase = HEX_TAKE;
            end
            HEX_TAKE: begin
                if (nib < 5'd16) begin
                    if (digit_cnt < COUNT_SAT) digit_cnt = digit_cnt + 1'b1;
                    digit_acc = {digit_acc[ACCUM_W-5:0], nib[3:0]};
                end else begin
                    hex_phase = HEX_DONE;
                end
            end
            default: ;
        endcase
        after_amp = (b == CH_AMP);
        // keyword matcher: after "PlayRes" the next byte decides X or Y
        if (key_len == KW_LEN) begin
            if (b == CH_X) saw_res_x = 1'b1;
            if (b == CH_Y) saw_res_y = 1'b1;
            key_len = (b == CH_P) ? 3'd1 : 3'd0;
        end else if (b == PLAYRES[55 - 8 * int'(key_len) -: 8]) begin
            key_len = key_len + 1'b1;
        end else begin
            key_len = (b == CH_P) ? 3'd1 : 3'd0;
        end
    endtask

    task automatic close_text_report(output t_report r);
        r = '0;
        if (hex_phase != HEX_SEEK) begin
            if (digit_cnt == COUNT_ARGB) begin
                r.color_found = 1'b1;
                r.color_alpha = ALPHA_OPAQUE - digit_acc[31:24];
                r.color_bgr   = digit_acc[23:0];
            end else if (digit_cnt == COUNT_RGB) begin
                r.color_found = 1'b1;
                r.color_alpha = ALPHA_OPAQUE;
                r.color_bgr   = digit_acc[23:0];
            end else begin
                r.status = 1'b1;
                r.reason = RSN_COLOR;
            end
        end
        if (!r.status && !(saw_res_x && saw_res_y)) begin
            r.reason            = RSN_RES;
            r.fallback_flag     = 1'b1;
            r.normalized_width  = fb_width;
            r.normalized_height = fb_height;
        end
        r.line_break_flag = break_seen;
        clear_text_state();
    endtask

    task automatic send_item(input logic [7:0] b, input logic present, input logic eot,
                             input logic typed, input t_report want);
        int      gap;
        t_report r;
        gap = idle_en ? $urandom_range(0, 13) : 0;
        repeat (gap) begin
            @(negedge i_clk);
            in_ch.valid <= 1'b0;
        end
        @(negedge i_clk);
        in_ch.valid        <= 1'b1;
        in_ch.text_byte    <= b;
        in_ch.byte_present <= present;
        in_ch.end_of_text  <= eot;
        @(posedge i_clk);
        while (in_ch.ready !== 1'b1) @(posedge i_clk);
        if (present) scan_text_byte(b);
        if (eot) begin
            close_text_report(r);
            reports_due.push_back(typed ? want : r);
            texts_sent++;
        end
    endtask

    // drop valid, let every report arrive, then cover the pipeline latency
    task automatic drain();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (reports_due.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_fallback(input logic [RES_W-1:0] w, input logic [RES_W-1:0] h);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_FALLBACK_WIDTH;
        i_cfg_data <= w;
        @(negedge i_clk);
        i_cfg_idx  <= CFG_FALLBACK_HEIGHT;
        i_cfg_data <= h;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        fb_width  = w;
        fb_height = h;
    endtask

    task automatic dir_row(input logic [7:0] b, input logic present, input logic eot,
                           input logic typed, input t_report want);
        t_dir_step s;
        s.b       = b;
        s.present = present;
        s.eot     = eot;
        s.typed   = typed;
        s.want    = want;
        dir_steps.push_back(s);
    endtask

    task automatic dir_text(input string s, input logic eot_last, input logic typed,
                            input t_report want);
        for (int i = 0; i < s.len(); i++)
            dir_row(s[i], 1'b1, eot_last && i == s.len() - 1, typed, want);
    endtask

    task automatic push_str(input string s);
        for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
    endtask

    task automatic push_keys();
        if ($urandom_range(0, 1)) begin
            push_str("PlayResX");
            push_str("PlayResY");
        end else begin
            push_str("PlayResY");
            push_str("PlayResX");
        end
    endtask

    task automatic push_color();
        int n;
        int r;
        int v;
        push_str("&H");
        r = $urandom_range(0, 99);
        n = (r < 35) ? 6 : (r < 70) ? 8 : $urandom_range(0, 11);
        repeat (n) begin
            v = $urandom_range(0, 15);
            if (v < 10) text_buf.push_back(8'(8'h30 + v));
            else if ($urandom_range(0, 1)) text_buf.push_back(8'(8'h41 + v - 10));
            else text_buf.push_back(8'(8'h61 + v - 10));
        end
    endtask

    // mostly well-formed texts with random content, some pure noise
    task automatic send_random_text();
        int    n;
        int    nseg;
        logic  want_keys;
        logic  keys_first;
        logic  end_only;
        string prefix;
        text_buf.delete();
        prefix = "PlayRe";
        if ($urandom_range(0, 99) < 12) begin
            n = $urandom_range(0, 12);
            repeat (n) text_buf.push_back(8'($urandom_range(0, 255)));
        end else begin
            want_keys  = ($urandom_range(0, 99) < 60);
            keys_first = 1'($urandom_range(0, 1));
            if (want_keys && keys_first) push_keys();
            nseg = $urandom_range(1, 6);
            repeat (nseg) begin
                case ($urandom_range(0, 9))
                    0, 1: begin
                        repeat ($urandom_range(1, 4))
                            text_buf.push_back(8'($urandom_range(0, 255)));
                    end
                    2: begin
                        push_str("\\N");
                    end
                    3: begin
                        push_str($urandom_range(0, 1) ? "\\n" : "N\\");
                    end
                    4, 5, 6: begin
                        push_color();
                    end
                    7: begin
                        push_str("PlayRes");
                        case ($urandom_range(0, 2))
                            0: text_buf.push_back(CH_X);
                            1: text_buf.push_back(CH_Y);
                            default: text_buf.push_back(8'($urandom_range(0, 255)));
                        endcase
                    end
                    8: begin
                        push_str(prefix.substr(0, $urandom_range(0, 5)));
                        text_buf.push_back(8'($urandom_range(0, 255)));
                    end
                    default: begin
                        push_str($urandom_range(0, 1) ? "&&H" : "&h");
                    end
                endcase
            end
            if (want_keys && !keys_first) push_keys();
        end
        end_only = (text_buf.size() == 0) || ($urandom_range(0, 99) < 30);
        foreach (text_buf[i]) begin
            if ($urandom_range(0, 99) < 4)
                send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0, '0);
            send_item(text_buf[i], 1'b1, !end_only && i == text_buf.size() - 1, 1'b0, '0);
            items_sent++;
        end
        if (end_only) begin
            send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1, 1'b0, '0);
            items_sent++;
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            fail_cnt++;
        end
    endtask

    // report sink: random stalls, compare each transaction with the oldest expectation
    initial begin
        int      stall;
        t_report want;
        out_ch.ready = 1'b0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            stall = idle_en ? $urandom_range(0, 13) : 0;
            repeat (stall) begin
                @(negedge i_clk);
                out_ch.ready <= 1'b0;
            end
            @(negedge i_clk);
            out_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (out_ch.valid !== 1'b1) @(posedge i_clk);
            reports_seen++;
            if (reports_due.size() == 0) begin
                $error("report with no text pending");
                fail_cnt++;
            end else begin
                want = reports_due.pop_front();
                check_field("status", 32'(want.status), 32'(out_ch.status));
                check_field("reason", 32'(want.reason), 32'(out_ch.reason));
                check_field("line_break_flag", 32'(want.line_break_flag),
                            32'(out_ch.line_break_flag));
                check_field("fallback_flag", 32'(want.fallback_flag),
                            32'(out_ch.fallback_flag));
                check_field("color_found", 32'(want.color_found), 32'(out_ch.color_found));
                check_field("color_alpha", 32'(want.color_alpha), 32'(out_ch.color_alpha));
                check_field("color_bgr", 32'(want.color_bgr), 32'(out_ch.color_bgr));
                check_field("normalized_width", 32'(want.normalized_width),
                            32'(out_ch.normalized_width));
                check_field("normalized_height", 32'(want.normalized_height),
                            32'(out_ch.normalized_height));
            end
        end
    end

    initial begin
        t_report fb_only;
        t_report bad_color;
        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_idx          = CFG_FALLBACK_WIDTH;
        i_cfg_data         = '0;
        in_ch.valid        = 1'b0;
        in_ch.text_byte    = '0;
        in_ch.byte_present = 1'b0;
        in_ch.end_of_text  = 1'b0;
        idle_en            = 1'b1;
        items_sent         = 0;
        texts_sent         = 0;
        reports_seen       = 0;
        fail_cnt           = 0;
        fb_width           = FALLBACK_W_RST;
        fb_height          = FALLBACK_H_RST;
        clear_text_state();

        fb_only   = report_of(1'b0, RSN_RES, 1'b0, 1'b1, 1'b0, 8'd0, 24'd0,
                              FALLBACK_W_RST, FALLBACK_H_RST);
        bad_color = report_of(1'b1, RSN_COLOR, 1'b0, 1'b0, 1'b0, 8'd0, 24'd0, 12'd0, 12'd0);

        // directed texts
        dir_row(8'h00, 1'b0, 1'b1, 1'b1, fb_only);              // empty text
        dir_row(8'hff, 1'b0, 1'b0, 1'b0, '0);                   // ignored item
        dir_text("&H", 1'b0, 1'b0, '0);                         // marker right at the end
        dir_row(8'h00, 1'b0, 1'b1, 1'b1, bad_color);
        dir_row(8'hff, 1'b1, 1'b1, 1'b1, fb_only);
        dir_row(8'h00, 1'b1, 1'b1, 1'b1, fb_only);
        dir_text("\\N", 1'b1, 1'b1, report_of(1'b0, RSN_RES, 1'b1, 1'b1, 1'b0, 8'd0, 24'd0,
                                              FALLBACK_W_RST, FALLBACK_H_RST));
        dir_text("&HFFFFFFFFF", 1'b1, 1'b1, bad_color);         // run saturates past 8
        dir_text("&H00aBcD", 1'b1, 1'b1, report_of(1'b0, RSN_RES, 1'b0, 1'b1, 1'b1, 8'hff,
                                                   24'h00abcd, FALLBACK_W_RST,
                                                   FALLBACK_H_RST));

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_steps[i])
            send_item(dir_steps[i].b, dir_steps[i].present, dir_steps[i].eot,
                      dir_steps[i].typed, dir_steps[i].want);

        for (int phase = 0; phase < 6; phase++) begin
            if (phase > 0) begin
                drain();
                case (phase)
                    1: write_fallback(12'd1, 12'd1);
                    2: write_fallback(12'd4095, 12'd4095);
                    3: write_fallback(12'($urandom_range(1, 4095)),
                                      12'($urandom_range(1, 4095)));
                    4: write_fallback(12'd4095, 12'd1);
                    default: write_fallback(12'd1, 12'($urandom_range(1, 4095)));
                endcase
            end
            // one phase runs back to back on both sides
            idle_en = (phase != 2);
            while (items_sent < (phase + 1) * 200) send_random_text();
        end
        drain();

        $display("scanned %0d texts in %0d byte transactions across six fallback settings",
                 texts_sent, items_sent + dir_steps.size());
        $display("compared %0d reports, %0d field mismatches", reports_seen, fail_cnt);
        if (fail_cnt == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
